[hdl/ffa_pkg.sv]
// Package for the first-fit free-list allocator: sizes, codes, cell types.
// Has no dependencies; every other file imports it.
package ffa_pkg;

  localparam int ENTRIES = 1024;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int LOG     = $clog2(ENTRIES);
  localparam int LVL_W   = $clog2(LOG + 1);

  localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
  localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_ALLOC_PG = 2'd2,
    OP_FREE_PG  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_LOST  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_APPLY,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_TAKE_PREV,
    ACT_TAKE_NEXT,
    ACT_LOAD,
    ACT_CARVE,
    ACT_GROW,
    ACT_GROW_SUCC,
    ACT_MERGE_BOTH
  } cell_act_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } extent_t;

  typedef struct packed {
    logic fit;     // length >= request size
    logic gt;      // start > request address
    logic endeq;   // start + length == request address
    logic succeq;  // request address + size == start
    logic empty;   // length == request size
  } cell_flags_t;

endpackage

[hdl/ffa_if.sv]
// Request and response channel interfaces of the allocator.
// Depends on ffa_pkg for the counter width.
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] req_size;
  logic [31:0] req_addr;
  modport source (output valid, opcode, req_size, req_addr, input ready);
  modport sink   (input valid, opcode, req_size, req_addr, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*;;
  logic             valid;
  logic             ready;
  logic [31:0]      alloc_addr;
  logic [1:0]       status;
  logic [31:0]      free_total;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] peak_entries;
  logic [31:0]      lost_count;
  logic [31:0]      lost_bytes;
  modport source (output valid, alloc_addr, status, free_total, entry_count,
                  peak_entries, lost_count, lost_bytes, input ready);
  modport sink   (input valid, alloc_addr, status, free_total, entry_count,
                  peak_entries, lost_count, lost_bytes, output ready);
endinterface

[hdl/first_fit_free_list_allocator_top.sv]
// First-fit free-list allocator with coalescing: top level.
// Depends on ffa_pkg, ffa_if, ffa_cell and ffa_scan.
//
// The block keeps an address-sorted table of free extents in a row of
// ENTRIES cells. A request transaction on req carries an opcode (allocate,
// free, and their 4 KiB page-rounded forms), a size and, for frees, an
// address. Each request produces exactly one response transaction on rsp
// with the allocated address, a status and the running counters.
//
// One request is handled at a time; req.ready is high only when the block
// is idle. Every request passes from acceptance to its response through
// an evaluate step in which all cells compare against the request, the
// prefix scan, and an apply step in which the cells carve, merge, insert
// or shift; then the response register is shown. The scan finds the first
// fitting extent for an allocation, and the first extent that starts above
// the address for a free. The next request can be accepted in the cycle
// after the response is taken.
//
// The response stays in its register, unchanged, for as long as rsp.ready
// is low; the block takes no new request until it has gone. Reset empties
// the table at once and clears all counters; table contents need no clear.
module first_fit_free_list_allocator_top import ffa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ffa_req_if.sink     req,
  ffa_rsp_if.source   rsp
);

  state_t state, state_next;

  // Captured request; page opcodes are rounded on the way in.
  logic        is_alloc;
  logic [31:0] size;
  logic [31:0] addr;

  // Table bookkeeping.
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] peak;
  logic [31:0]      free_sum;
  logic [31:0]      lost_cnt;
  logic [31:0]      lost_bytes;

  extent_t            ext   [ENTRIES];
  cell_flags_t        flags [ENTRIES];
  cell_act_t          act   [ENTRIES];
  logic [ENTRIES-1:0] valid_v, fit_v, gt_v, scan_in, below, predcell, kcell, first, pfx;
  logic               scan_done, found, emptied, pm, sm;
  logic [31:0]        sel_start;
  logic [CNT_W-1:0]   used_new;

  // Row of cells; each one sees its neighbors' extents only.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    extent_t prev_e, next_e;
    if (i == 0) begin : g_first
      assign prev_e = '0;
    end else begin : g_mid
      assign prev_e = ext[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = ext[i+1];
    end
    ffa_cell u_cell (
      .clk   (clk),
      .eval  (state == S_EVAL),
      .size  (size),
      .addr  (addr),
      .act   (act[i]),
      .prev  (prev_e),
      .next  (next_e),
      .ext   (ext[i]),
      .flags (flags[i])
    );
  end

  // The scan runs over the fit flags for an allocation and over the
  // "starts above the address" flags for a free.
  ffa_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (state == S_SCAN),
    .din  (scan_in),
    .vec  (pfx),
    .done (scan_done)
  );

  // Per-cell position terms: each is built from a cell and its neighbor.
  // For a free, below marks the cells ahead of the first one that starts
  // above the address, which keeps it a prefix even in an unsorted table.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_v[i] = CNT_W'(i) < used;
      fit_v[i]   = valid_v[i] & flags[i].fit;
      gt_v[i]    = valid_v[i] & flags[i].gt;
      scan_in[i] = is_alloc ? fit_v[i] : gt_v[i];
      below[i]   = valid_v[i] & ~pfx[i];
    end
    for (int i = 0; i < ENTRIES; i++) begin
      predcell[i] = below[i] & ((i == ENTRIES - 1) ? 1'b1 : ~below[(i + 1) % ENTRIES]);
      kcell[i]    = ~below[i] & ((i == 0) ? 1'b1 : below[(i + ENTRIES - 1) % ENTRIES]);
      first[i]    = pfx[i] & ((i == 0) ? 1'b1 : ~pfx[(i + ENTRIES - 1) % ENTRIES]);
    end
    found     = pfx[ENTRIES-1];
    emptied   = |(first & {ENTRIES{1'b0}}) ;
    pm        = 1'b0;
    sm        = 1'b0;
    sel_start = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      emptied   = emptied | (first[i] & flags[i].empty);
      pm        = pm | (predcell[i] & flags[i].endeq);
      sm        = sm | (kcell[i] & valid_v[i] & flags[i].succeq);
      sel_start = sel_start | (first[i] ? ext[i].start : 32'd0);
    end
  end

  // Cell actions for the update cycle.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      act[i] = ACT_HOLD;
      if (state == S_APPLY) begin
        if (is_alloc) begin
          if (found) begin
            if (emptied) begin
              if (pfx[i] & valid_v[i]) act[i] = ACT_TAKE_NEXT;
            end else if (first[i]) begin
              act[i] = ACT_CARVE;
            end
          end
        end else if (pm && sm) begin
          if (predcell[i]) begin
            act[i] = ACT_MERGE_BOTH;
          end else if (~below[i] & valid_v[i]) begin
            act[i] = ACT_TAKE_NEXT;
          end
        end else if (pm) begin
          if (predcell[i]) act[i] = ACT_GROW;
        end else if (sm) begin
          if (kcell[i]) act[i] = ACT_GROW_SUCC;
        end else if (used < CNT_W'(ENTRIES)) begin
          if (kcell[i]) begin
            act[i] = ACT_LOAD;
          end else if (~below[i] && i > 0 && valid_v[(i + ENTRIES - 1) % ENTRIES]) begin
            act[i] = ACT_TAKE_PREV;
          end
        end
      end
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    rsp.valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) state_next = S_EVAL;
      end
      S_EVAL:  state_next = S_SCAN;
      S_SCAN:  if (scan_done) state_next = S_APPLY;
      S_APPLY: state_next = S_OUT;
      S_OUT: begin
        rsp.valid = 1'b1;
        if (rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    used_new = used;
    if (is_alloc) begin
      if (found && emptied) used_new = used - CNT_W'(1);
    end else if (pm && sm) begin
      used_new = used - CNT_W'(1);
    end else if (!pm && !sm && used < CNT_W'(ENTRIES)) begin
      used_new = used + CNT_W'(1);
    end
  end

  // Request capture, counters and the response register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      is_alloc <= (req.opcode == OP_ALLOC) || (req.opcode == OP_ALLOC_PG);
      addr     <= req.req_addr;
      if ((req.opcode == OP_ALLOC_PG) || (req.opcode == OP_FREE_PG)) begin
        size <= (req.req_size + PAGE_ADD) & PAGE_MASK;
      end else begin
        size <= req.req_size;
      end
    end
    if (state == S_APPLY) begin
      rsp.alloc_addr <= '0;
      rsp.status     <= ST_OK;
      if (is_alloc) begin
        if (found) begin
          rsp.alloc_addr <= sel_start;
        end else begin
          rsp.status <= ST_NOFIT;
        end
      end else if (!pm && !sm && used == CNT_W'(ENTRIES)) begin
        rsp.status <= ST_LOST;
      end
    end
    if (rst) begin
      used       <= '0;
      peak       <= '0;
      free_sum   <= '0;
      lost_cnt   <= '0;
      lost_bytes <= '0;
    end else if (state == S_APPLY) begin
      used <= used_new;
      if (used_new > peak) peak <= used_new;
      if (is_alloc) begin
        if (found) free_sum <= free_sum - size;
      end else if (pm || sm || used < CNT_W'(ENTRIES)) begin
        free_sum <= free_sum + size;
      end else begin
        lost_cnt   <= lost_cnt + 32'd1;
        lost_bytes <= lost_bytes + size;
      end
    end
  end

  assign rsp.free_total   = free_sum;
  assign rsp.entry_count  = used;
  assign rsp.peak_entries = peak;
  assign rsp.lost_count   = lost_cnt;
  assign rsp.lost_bytes   = lost_bytes;

endmodule

[hdl/ffa_cell.sv]
// One slot of the extent table: holds one extent, compares it against the
// current request and updates itself from its neighbors. Depends on ffa_pkg.
module ffa_cell import ffa_pkg::*; (
  input  logic        clk,
  input  logic        eval,
  input  logic [31:0] size,
  input  logic [31:0] addr,
  input  cell_act_t   act,
  input  extent_t     prev,
  input  extent_t     next,
  output extent_t     ext,
  output cell_flags_t flags
);

  always_ff @(posedge clk) begin
    if (eval) begin
      flags.fit    <= ext.length >= size;
      flags.gt     <= ext.start > addr;
      flags.endeq  <= (ext.start + ext.length) == addr;
      flags.succeq <= (addr + size) == ext.start;
      flags.empty  <= ext.length == size;
    end
    unique case (act)
      ACT_HOLD:       ext <= ext;
      ACT_TAKE_PREV:  ext <= prev;
      ACT_TAKE_NEXT:  ext <= next;
      ACT_LOAD: begin
        ext.start  <= addr;
        ext.length <= size;
      end
      ACT_CARVE: begin
        ext.start  <= ext.start + size;
        ext.length <= ext.length - size;
      end
      ACT_GROW:       ext.length <= ext.length + size;
      ACT_GROW_SUCC: begin
        ext.start  <= addr;
        ext.length <= ext.length + size;
      end
      ACT_MERGE_BOTH: ext.length <= ext.length + size + next.length;
      default:        ext <= ext;
    endcase
  end

endmodule

[hdl/ffa_scan.sv]
// Registered prefix-OR over one flag per cell, one doubling step per cycle,
// to find the first cell whose flag is set. Depends on ffa_pkg.
module ffa_scan import ffa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [ENTRIES-1:0] din,
  output logic [ENTRIES-1:0] vec,
  output logic               done
);

  logic [LVL_W-1:0]   lvl;
  logic [ENTRIES-1:0] src;
  logic [LOG-1:0]     span;

  always_comb begin
    src  = (lvl == '0) ? din : vec;
    span = LOG'(1) << lvl;
    done = step && (lvl == LVL_W'(LOG - 1));
  end

  always_ff @(posedge clk) begin
    if (step) begin
      vec <= src | (src << span);
    end
    if (rst) begin
      lvl <= '0;
    end else if (done) begin
      lvl <= '0;
    end else if (step) begin
      lvl <= lvl + LVL_W'(1);
    end
  end

endmodule

[hdl/ffa_checker.sv]
// Port-level checks for the allocator top level, and the bind that attaches
// them. Depends on ffa_pkg and first_fit_free_list_allocator_top.
module ffa_checker import ffa_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [31:0]      alloc_addr,
  input logic [1:0]       status,
  input logic [CNT_W-1:0] entry_count,
  input logic [CNT_W-1:0] peak_entries
);

  // Only one request is in flight: no new one while a response waits.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while response pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (entry_count <= CNT_W'(ENTRIES) && peak_entries >= entry_count))
    else $error("entry count out of bounds");

  a_nofit_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_NOFIT) |-> alloc_addr == 32'd0)
    else $error("failed allocation returned an address");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("response dropped while stalled");

endmodule

bind first_fit_free_list_allocator_top ffa_checker u_ffa_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .alloc_addr   (rsp.alloc_addr),
  .status       (rsp.status),
  .entry_count  (rsp.entry_count),
  .peak_entries (rsp.peak_entries)
);
